// ===== rtl/kgc_pkg.sv =====
// Shared constants, register codes and types for the keyframe gradient color block.
// No dependencies; imported by every module of the block.
package kgc_pkg;

    // Stored slots for palette colors and keyframes
    localparam int SLOTS = 4;

    // Parameter defaults
    localparam int MAX_COLORS_DEF    = 4;
    localparam int MAX_KEYFRAMES_DEF = 4;
    localparam int CHANNELS_DEF      = 4;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int KT_W     = 16;
    localparam int PERIOD_W = 18;
    localparam int LEVEL_W  = 16;
    localparam int GP_W     = 15;
    localparam int CH_W     = 8;
    localparam int COLOR_W  = 32;
    localparam int CFG_W    = 64;
    localparam int IDX_W    = 3;
    localparam int CNT_W    = 3;
    localparam int OUT_W    = 48;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_COLOR_COUNT = 3'd0,
        REG_PALETTE_0   = 3'd1,
        REG_PALETTE_1   = 3'd2,
        REG_PALETTE_2   = 3'd3,
        REG_PALETTE_3   = 3'd4,
        REG_KF_COUNT    = 3'd5,
        REG_KF_TIMES    = 3'd6,
        REG_KF_LEVELS   = 3'd7
    } reg_idx_t;

    // Reset values
    localparam logic [CNT_W-1:0]   COLOR_COUNT_RST = 3'd2;
    localparam logic [CNT_W-1:0]   KF_COUNT_RST    = 3'd2;
    localparam logic [COLOR_W-1:0] PAL0_RST        = 32'h0000_0000;
    localparam logic [COLOR_W-1:0] PAL1_RST        = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] PAL2_RST        = 32'h0000_0000;
    localparam logic [COLOR_W-1:0] PAL3_RST        = 32'h0000_0000;
    localparam logic [CFG_W-1:0]   KF_TIMES_RST    = 64'h0000_0000_03E8_0000;
    localparam logic [CFG_W-1:0]   KF_LEVELS_RST   = 64'h0000_0000_FFFF_0000;

    typedef logic [COLOR_W-1:0] color_t;

endpackage

// ===== rtl/kgc_mod.sv =====
// Pipelined time reduction: time modulo keyframe period, one quotient bit per stage.
// Depends on kgc_pkg.
module kgc_mod (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [kgc_pkg::TIME_W-1:0]     in_time,
    input  logic [kgc_pkg::PERIOD_W-1:0]   period,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [kgc_pkg::PERIOD_W-1:0]   out_time
);
    import kgc_pkg::*;

    localparam int N = TIME_W;

    logic [N-1:0]        v_reg;
    logic [N-1:0]        en;
    logic [PERIOD_W-1:0] rem_reg [N];
    logic [TIME_W-1:0]   tsh_reg [N];
    logic [PERIOD_W-1:0] rem_next [N];
    logic [TIME_W-1:0]   tsh_next [N];

    // One restoring step: shift in the next time bit, subtract period if it fits
    function automatic logic [PERIOD_W-1:0] mod_step(input logic [PERIOD_W-1:0] rem,
                                                     input logic bit_in,
                                                     input logic [PERIOD_W-1:0] p);
        logic [PERIOD_W:0] top;
        top = {rem, bit_in};
        if (top >= {1'b0, p})
        begin
            top = top - {1'b0, p};
        end
        return top[PERIOD_W-1:0];
    endfunction

    // Stall chain
    always_comb
    begin
        en[N-1] = !v_reg[N-1] || out_ready;
        for (int k = N-2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    // Next stage values
    always_comb
    begin
        rem_next[0] = mod_step('0, in_time[TIME_W-1], period);
        tsh_next[0] = {in_time[TIME_W-2:0], 1'b0};
        for (int k = 1; k < N; k++)
        begin
            rem_next[k] = mod_step(rem_reg[k-1], tsh_reg[k-1][TIME_W-1], period);
            tsh_next[k] = {tsh_reg[k-1][TIME_W-2:0], 1'b0};
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < N; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            if (en[k])
            begin
                rem_reg[k] <= rem_next[k];
                tsh_reg[k] <= tsh_next[k];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[N-1];
    // zero period maps every time to 0
    assign out_time  = (period == '0) ? '0 : rem_reg[N-1];

endmodule

// ===== rtl/kgc_seg.sv =====
// Segment search and interpolation numerator over three stages.
// Depends on kgc_pkg.
module kgc_seg #(
    parameter int MAX_KEYFRAMES = kgc_pkg::MAX_KEYFRAMES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [kgc_pkg::PERIOD_W-1:0]  in_time,
    input  logic [kgc_pkg::CNT_W-1:0]     kf_count,
    input  logic [kgc_pkg::CFG_W-1:0]     kf_times,
    input  logic [kgc_pkg::CFG_W-1:0]     kf_levels,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2*kgc_pkg::KT_W-1:0]    out_num,
    output logic [kgc_pkg::KT_W-1:0]      out_w
);
    import kgc_pkg::*;

    localparam int CAP = (MAX_KEYFRAMES < SLOTS) ? MAX_KEYFRAMES : SLOTS;
    localparam int N   = 3;

    logic [N-1:0]       v_reg;
    logic [N-1:0]       en;
    logic [CNT_W-1:0]   nk;

    // stage 0: segment
    logic [KT_W-1:0]    d_reg, w_reg, la_reg, lb_reg;
    logic [KT_W-1:0]    d_next, w_next, la_next, lb_next;
    // stage 1: products
    logic [2*KT_W-1:0]  pa_reg, pb_reg;
    logic [KT_W-1:0]    w1_reg;
    // stage 2: numerator
    logic [2*KT_W-1:0]  num_reg;
    logic [KT_W-1:0]    w2_reg;
    logic [2*KT_W:0]    num_sum;

    // Effective keyframe count
    always_comb
    begin
        nk = kf_count;
        if (nk < CNT_W'(2))
        begin
            nk = CNT_W'(2);
        end
        if (nk > CNT_W'(CAP))
        begin
            nk = CNT_W'(CAP);
        end
    end

    // Segment search, closed lower edge, highest match wins
    always_comb
    begin
        logic [KT_W-1:0] ta, tb;
        logic [1:0]      seg;
        seg    = '0;
        d_next = '0;
        w_next = KT_W'(1);
        for (int i = 0; i < SLOTS-1; i++)
        begin
            ta = kf_times[i*KT_W +: KT_W];
            tb = kf_times[(i+1)*KT_W +: KT_W];
            if ((CNT_W'(i+1) < nk) && ({2'b00, ta} <= in_time) && (in_time < {2'b00, tb}))
            begin
                seg    = 2'(i);
                d_next = in_time[KT_W-1:0] - ta;
                w_next = tb - ta;
            end
        end
        la_next = kf_levels[seg*KT_W +: KT_W];
        lb_next = (seg == 2'(SLOTS-1)) ? '0 : kf_levels[(seg+2'd1)*KT_W +: KT_W];
    end

    assign num_sum = {1'b0, pa_reg} + {1'b0, pb_reg} + {{(KT_W+2){1'b0}}, w1_reg[KT_W-1:1]};

    // Stall chain
    always_comb
    begin
        en[N-1] = !v_reg[N-1] || out_ready;
        for (int k = N-2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d_reg  <= d_next;
            w_reg  <= w_next;
            la_reg <= la_next;
            lb_reg <= lb_next;
        end
        if (en[1])
        begin
            pa_reg <= la_reg * (w_reg - d_reg);
            pb_reg <= lb_reg * d_reg;
            w1_reg <= w_reg;
        end
        if (en[2])
        begin
            // sum stays below 2^32 since both weights add up to w
            num_reg <= num_sum[2*KT_W-1:0];
            w2_reg  <= w1_reg;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[N-1];
    assign out_num   = num_reg;
    assign out_w     = w2_reg;

endmodule

// ===== rtl/kgc_div.sv =====
// Pipelined restoring divider for the interpolated level, one quotient bit per stage.
// Depends on kgc_pkg.
module kgc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2*kgc_pkg::KT_W-1:0]    in_num,
    input  logic [kgc_pkg::KT_W-1:0]      in_w,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [kgc_pkg::LEVEL_W-1:0]   out_level
);
    import kgc_pkg::*;

    localparam int N = LEVEL_W;
    localparam int XW = 2*KT_W;

    logic [N-1:0]    v_reg;
    logic [N-1:0]    en;
    // upper half partial remainder, lower half dividend bits then quotient bits
    logic [XW-1:0]   x_reg [N];
    logic [KT_W-1:0] w_reg [N];
    logic [XW-1:0]   x_next [N];

    function automatic logic [XW-1:0] div_step(input logic [XW-1:0] x,
                                               input logic [KT_W-1:0] w);
        logic [KT_W:0] top;
        logic          q;
        top = x[XW-1:KT_W-1];
        q   = (top >= {1'b0, w});
        if (q)
        begin
            top = top - {1'b0, w};
        end
        return {top[KT_W-1:0], x[KT_W-2:0], q};
    endfunction

    always_comb
    begin
        x_next[0] = div_step(in_num, in_w);
        for (int k = 1; k < N; k++)
        begin
            x_next[k] = div_step(x_reg[k-1], w_reg[k-1]);
        end
    end

    // Stall chain
    always_comb
    begin
        en[N-1] = !v_reg[N-1] || out_ready;
        for (int k = N-2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < N; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg[0] <= x_next[0];
            w_reg[0] <= in_w;
        end
        for (int k = 1; k < N; k++)
        begin
            if (en[k])
            begin
                x_reg[k] <= x_next[k];
                w_reg[k] <= w_reg[k-1];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[N-1];
    assign out_level = x_reg[N-1][LEVEL_W-1:0];

endmodule

// ===== rtl/kgc_blend.sv =====
// Palette pick and per-channel blend over three stages, the last one the output register.
// Depends on kgc_pkg.
module kgc_blend #(
    parameter int MAX_COLORS = kgc_pkg::MAX_COLORS_DEF,
    parameter int CHANNELS   = kgc_pkg::CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [kgc_pkg::LEVEL_W-1:0]   in_level,
    input  logic [kgc_pkg::CNT_W-1:0]     color_count,
    input  kgc_pkg::color_t               palette [kgc_pkg::SLOTS],
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [kgc_pkg::OUT_W-1:0]     out_data
);
    import kgc_pkg::*;

    localparam int CAP  = (MAX_COLORS < SLOTS) ? MAX_COLORS : SLOTS;
    localparam int N    = 3;
    localparam int PW   = CNT_W + GP_W;
    localparam int FW   = 16;
    localparam int PRW  = CH_W + FW + 1;

    logic [N-1:0]     v_reg;
    logic [N-1:0]     en;
    logic [CNT_W-1:0] nc;
    logic [GP_W-1:0]  gp;
    logic [PW-1:0]    p;
    logic [CNT_W-1:0] lo, hi;
    logic [FW-1:0]    frac;

    // stage 0
    color_t           ca_reg, cb_reg;
    logic [FW-1:0]    f_reg;
    logic [GP_W-1:0]  gp0_reg;
    // stage 1
    logic [PRW-1:0]   pa_reg [4];
    logic [PRW-1:0]   pb_reg [4];
    logic [GP_W-1:0]  gp1_reg;
    // stage 2
    logic [OUT_W-1:0] out_reg;
    logic [OUT_W-1:0] out_next;

    // Effective color count
    always_comb
    begin
        nc = color_count;
        if (nc < CNT_W'(1))
        begin
            nc = CNT_W'(1);
        end
        if (nc > CNT_W'(CAP))
        begin
            nc = CNT_W'(CAP);
        end
    end

    // Position along palette, clamped color indexes
    always_comb
    begin
        gp   = in_level[LEVEL_W-1:1];
        p    = nc * gp;
        lo   = CNT_W'(p[PW-1:FW]);
        frac = p[FW-1:0];
        hi   = (frac != '0) ? lo + CNT_W'(1) : lo;
        if (lo > nc - CNT_W'(1)) lo = nc - CNT_W'(1);
        if (hi > nc - CNT_W'(1)) hi = nc - CNT_W'(1);
    end

    // Rounded blend, channels beyond CHANNELS read zero
    always_comb
    begin
        logic [PRW:0] s;
        out_next = '0;
        for (int j = 0; j < 4; j++)
        begin
            s = {1'b0, pa_reg[j]} + {1'b0, pb_reg[j]} + (PRW+1)'(32768);
            if (j < CHANNELS)
            begin
                out_next[j*CH_W +: CH_W] = s[FW +: CH_W];
            end
        end
        out_next[4*CH_W +: GP_W] = gp1_reg;
    end

    // Stall chain
    always_comb
    begin
        en[N-1] = !v_reg[N-1] || out_ready;
        for (int k = N-2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ca_reg  <= palette[lo[1:0]];
            cb_reg  <= palette[hi[1:0]];
            f_reg   <= frac;
            gp0_reg <= gp;
        end
        if (en[1])
        begin
            for (int j = 0; j < 4; j++)
            begin
                pa_reg[j] <= ca_reg[j*CH_W +: CH_W] * ((FW+1)'(65536) - {1'b0, f_reg});
                pb_reg[j] <= cb_reg[j*CH_W +: CH_W] * {1'b0, f_reg};
            end
            gp1_reg <= gp0_reg;
        end
        if (en[2])
        begin
            out_reg <= out_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[N-1];
    assign out_data  = out_reg;

endmodule

// ===== rtl/keyframe_gradient_color.sv =====
// Top level of the keyframe gradient color block: registers and pipeline chain.
// Depends on kgc_pkg, kgc_mod, kgc_seg, kgc_div, kgc_blend.
//
// Takes one millisecond time per cycle unless back pressure holds it, and returns one
// blended color per time, in order: 32 stages of the modulo-period reduction (one
// bit each), 3 stages of segment search and numerator, 16 stages of the level
// divider (one quotient bit each) and 3 stages of palette blend, the last being
// the output register. Every stage moves on its own valid bit, so bubbles close
// up under back pressure. Configuration writes are always taken (cfg_ready is
// tied high) and belong to idle periods.
module keyframe_gradient_color #(
    parameter int MAX_COLORS    = kgc_pkg::MAX_COLORS_DEF,
    parameter int MAX_KEYFRAMES = kgc_pkg::MAX_KEYFRAMES_DEF,
    parameter int CHANNELS      = kgc_pkg::CHANNELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [kgc_pkg::TIME_W-1:0]   s_tdata,   // time_ms
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [kgc_pkg::OUT_W-1:0]    m_tdata,   // channel_0..channel_3, gradient_position, pad
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [kgc_pkg::IDX_W-1:0]    cfg_index,
    input  logic [kgc_pkg::CFG_W-1:0]    cfg_data
);
    import kgc_pkg::*;

    logic [CNT_W-1:0]    color_count_reg;
    logic [CNT_W-1:0]    kf_count_reg;
    color_t              palette_reg [SLOTS];
    logic [CFG_W-1:0]    kf_times_reg;
    logic [CFG_W-1:0]    kf_levels_reg;
    logic [CNT_W-1:0]    nk;
    logic [PERIOD_W-1:0] period;

    logic                mod_valid, mod_ready;
    logic [PERIOD_W-1:0] red_time;
    logic                seg_valid, seg_ready;
    logic [2*KT_W-1:0]   seg_num;
    logic [KT_W-1:0]     seg_w;
    logic                div_valid, div_ready;
    logic [LEVEL_W-1:0]  div_level;

    localparam int KCAP = (MAX_KEYFRAMES < SLOTS) ? MAX_KEYFRAMES : SLOTS;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_count_reg <= COLOR_COUNT_RST;
            kf_count_reg    <= KF_COUNT_RST;
            palette_reg[0]  <= PAL0_RST;
            palette_reg[1]  <= PAL1_RST;
            palette_reg[2]  <= PAL2_RST;
            palette_reg[3]  <= PAL3_RST;
            kf_times_reg    <= KF_TIMES_RST;
            kf_levels_reg   <= KF_LEVELS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_COLOR_COUNT: color_count_reg <= cfg_data[CNT_W-1:0];
                REG_PALETTE_0:   palette_reg[0]  <= cfg_data[COLOR_W-1:0];
                REG_PALETTE_1:   palette_reg[1]  <= cfg_data[COLOR_W-1:0];
                REG_PALETTE_2:   palette_reg[2]  <= cfg_data[COLOR_W-1:0];
                REG_PALETTE_3:   palette_reg[3]  <= cfg_data[COLOR_W-1:0];
                REG_KF_COUNT:    kf_count_reg    <= cfg_data[CNT_W-1:0];
                REG_KF_TIMES:    kf_times_reg    <= cfg_data;
                REG_KF_LEVELS:   kf_levels_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Keyframe period: sum of the times in use
    always_comb
    begin
        nk = kf_count_reg;
        if (nk < CNT_W'(2)) nk = CNT_W'(2);
        if (nk > CNT_W'(KCAP)) nk = CNT_W'(KCAP);
        period = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (CNT_W'(i) < nk)
            begin
                period = period + PERIOD_W'(kf_times_reg[i*KT_W +: KT_W]);
            end
        end
    end

    kgc_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_time   (s_tdata),
        .period    (period),
        .out_valid (mod_valid),
        .out_ready (mod_ready),
        .out_time  (red_time)
    );

    kgc_seg #(.MAX_KEYFRAMES(MAX_KEYFRAMES)) u_seg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mod_valid),
        .in_ready  (mod_ready),
        .in_time   (red_time),
        .kf_count  (kf_count_reg),
        .kf_times  (kf_times_reg),
        .kf_levels (kf_levels_reg),
        .out_valid (seg_valid),
        .out_ready (seg_ready),
        .out_num   (seg_num),
        .out_w     (seg_w)
    );

    kgc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seg_valid),
        .in_ready  (seg_ready),
        .in_num    (seg_num),
        .in_w      (seg_w),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_level (div_level)
    );

    kgc_blend #(.MAX_COLORS(MAX_COLORS), .CHANNELS(CHANNELS)) u_blend (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (div_valid),
        .in_ready    (div_ready),
        .in_level    (div_level),
        .color_count (color_count_reg),
        .palette     (palette_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata)
    );

    // Items in flight, for the checks below
    logic [6:0] inflight_reg;
    logic [6:0] inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (s_tvalid && s_tready) inflight_next = inflight_next + 7'd1;
        if (m_tvalid && m_tready) inflight_next = inflight_next - 7'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A result only appears for an item that went in
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (inflight_reg != 7'd0))
        else $error("result without a pending item");

    // Pipeline never holds more items than it has stages
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 7'd54)
        else $error("item count exceeds pipeline depth");

    // Padding bit stays clear on any result
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_W-1] == 1'b0))
        else $error("padding bit set");

endmodule

// ===== dv/tb_keyframe_gradient_color.sv =====
// Self-checking testbench for keyframe_gradient_color: directed and random time items,
// register settings between phases, random idling on both sides. Depends on kgc_pkg.
`timescale 1ns / 100ps

module tb_keyframe_gradient_color;
    import kgc_pkg::*;

    localparam int LATENCY   = 54;
    localparam int WD_LIMIT  = 20000;

    typedef struct packed {
        logic [GP_W-1:0] gp;
        logic [CH_W-1:0] ch3;
        logic [CH_W-1:0] ch2;
        logic [CH_W-1:0] ch1;
        logic [CH_W-1:0] ch0;
    } color_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [TIME_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // Predictor copy of the registers
    logic [CNT_W-1:0] mdl_ncolors;
    color_t mdl_pal [SLOTS];
    logic [CNT_W-1:0] mdl_nkeys;
    logic [CFG_W-1:0] mdl_ktimes;
    logic [CFG_W-1:0] mdl_klevels;

    color_res_t expected_colors[$];
    int errors = 0;
    int idle_cycles = 0;
    bit hold_sink = 1'b0;

    keyframe_gradient_color u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata),   // time_ms
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata),   // ch0, ch1, ch2, ch3, gradient_position, pad
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic color_res_t predict_color(logic [TIME_W-1:0] tm);
        int unsigned nk, nc, period, t, seg, d, w, ta, tb, lo, hi, frac, p, gp, v, ca, cb;
        longint unsigned la, lb, num, level;
        color_res_t r;
        nk = mdl_nkeys; if (nk < 2) nk = 2; if (nk > 4) nk = 4;
        nc = mdl_ncolors; if (nc < 1) nc = 1; if (nc > 4) nc = 4;
        period = 0;
        for (int i = 0; i < nk; i++) period += mdl_ktimes[16*i +: 16];
        t = (period == 0) ? 0 : tm % period;
        seg = 0; d = 0; w = 1;
        for (int i = 0; i + 1 < nk; i++) begin
            ta = mdl_ktimes[16*i +: 16];
            tb = mdl_ktimes[16*(i+1) +: 16];
            if (ta <= t && t < tb) begin
                seg = i; d = t - ta; w = tb - ta;
            end
        end
        la = mdl_klevels[16*seg +: 16];
        lb = mdl_klevels[16*(seg+1) +: 16];
        num = la * longint'(w - d) + lb * longint'(d) + longint'(w / 2);
        level = num / w;
        if (level > 64'hFFFF) level = 64'hFFFF;
        gp = level >> 1;
        p = nc * gp;
        lo = p >> 16;
        frac = p & 32'hFFFF;
        hi = (frac != 0) ? lo + 1 : lo;
        if (lo > nc - 1) lo = nc - 1;
        if (hi > nc - 1) hi = nc - 1;
        r = '0;
        for (int j = 0; j < 4; j++) begin
            ca = (mdl_pal[lo] >> (8*j)) & 8'hFF;
            cb = (mdl_pal[hi] >> (8*j)) & 8'hFF;
            v = (ca * (65536 - frac) + cb * frac + 32768) >> 16;
            if (v > 255) v = 255;
            case (j)
                0: r.ch0 = v[7:0];
                1: r.ch1 = v[7:0];
                2: r.ch2 = v[7:0];
                default: r.ch3 = v[7:0];
            endcase
        end
        r.gp = gp[GP_W-1:0];
        return r;
    endfunction

    // Valid stays up on return so the next item can follow at once; drain drops it
    task automatic send_time(logic [TIME_W-1:0] tm, bit gaps = 1'b1);
        int gap;
        gap = gaps ? $urandom_range(0, 14) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tm;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_colors.push_back(predict_color(tm));
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_colors.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_COLOR_COUNT: mdl_ncolors = val[CNT_W-1:0];
            REG_PALETTE_0:   mdl_pal[0] = val[31:0];
            REG_PALETTE_1:   mdl_pal[1] = val[31:0];
            REG_PALETTE_2:   mdl_pal[2] = val[31:0];
            REG_PALETTE_3:   mdl_pal[3] = val[31:0];
            REG_KF_COUNT:    mdl_nkeys = val[CNT_W-1:0];
            REG_KF_TIMES:    mdl_ktimes = val;
            default:         mdl_klevels = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random but mostly increasing keyframe times so segments are found
    function automatic logic [CFG_W-1:0] rand_times();
        logic [CFG_W-1:0] v;
        int unsigned acc;
        if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
        acc = $urandom_range(0, 50);
        for (int i = 0; i < 4; i++) begin
            v[16*i +: 16] = acc[15:0];
            acc += ($urandom_range(0, 1) ? $urandom_range(1, 200) : $urandom_range(1, 16000));
            if (acc > 65535) acc = 65535;
        end
        return v;
    endfunction

    task automatic random_config();
        write_reg(REG_COLOR_COUNT, $urandom_range(0, 7));
        write_reg(REG_PALETTE_0, $urandom);
        write_reg(REG_PALETTE_1, $urandom);
        write_reg(REG_PALETTE_2, $urandom);
        write_reg(REG_PALETTE_3, $urandom);
        write_reg(REG_KF_COUNT, $urandom_range(0, 7));
        write_reg(REG_KF_TIMES, rand_times());
        write_reg(REG_KF_LEVELS, {$urandom, $urandom});
    endtask

    // Random times, some near zero, the top of the time range and keyframe edges
    function automatic logic [TIME_W-1:0] rand_time();
        int unsigned k;
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 70000);
            2: begin
                k = $urandom_range(0, 3);
                return mdl_ktimes[16*k +: 16] + $urandom_range(0, 2) - 1;
            end
            3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    task automatic test_reset_values();
        logic [TIME_W-1:0] dir [12] = '{0, 1, 499, 500, 999, 1000, 1001, 32'hFFFF_FFFF,
                                       32'h8000_0000, 32'h7FFF_FFFF, 250, 750};
        foreach (dir[i]) send_time(dir[i]);
        drain();
    endtask

    task automatic test_extremes();
        // all registers at extremes
        write_reg(REG_COLOR_COUNT, 3'd4);
        write_reg(REG_PALETTE_0, 32'h0000_0000);
        write_reg(REG_PALETTE_1, 32'hFFFF_FFFF);
        write_reg(REG_PALETTE_2, 32'h00FF_00FF);
        write_reg(REG_PALETTE_3, 32'hA5A5_5A5A);
        write_reg(REG_KF_COUNT, 3'd4);
        write_reg(REG_KF_TIMES, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_KF_LEVELS, 64'hFFFF_0000_FFFF_0000);
        send_time(32'hFFFF_FFFF); send_time(0); send_time(65535); send_time(262139);
        drain();
        // zero period
        write_reg(REG_KF_TIMES, 64'h0);
        send_time(12345); send_time(32'hFFFF_FFFF);
        drain();
        // non-increasing times, counts below range
        write_reg(REG_KF_TIMES, 64'h0064_0064_0032_0000);
        write_reg(REG_COLOR_COUNT, 3'd0);
        write_reg(REG_KF_COUNT, 3'd0);
        send_time(10); send_time(60); send_time(99);
        drain();
        // counts above range, no segment holds the time
        write_reg(REG_COLOR_COUNT, 3'd7);
        write_reg(REG_KF_COUNT, 3'd7);
        write_reg(REG_KF_TIMES, 64'h0001_0001_0005_0009);
        write_reg(REG_KF_LEVELS, 64'h1234_FFFF_8000_7FFF);
        send_time(2); send_time(15); send_time(8);
        drain();
    endtask

    task automatic test_random(int n_items);
        for (int ph = 0; ph < 12; ph++) begin
            random_config();
            for (int i = 0; i < n_items / 12; i++) send_time(rand_time(), ph % 4 != 3);
            drain();
        end
    endtask

    task automatic test_backpressure();
        hold_sink = 1'b1;
        for (int i = 0; i < 120; i++) send_time(rand_time(), 1'b0);
        drain();
        // sender pauses until everything is back
        for (int i = 0; i < 20; i++) send_time(rand_time());
        drain();
    endtask

    // Result sink with its own stalls and one long hold-off
    initial begin
        int stall;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_sink = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // Result checker
    always @(posedge clk) begin
        color_res_t got, exp_c;
        if (rst_n && m_tvalid && m_tready) begin
            got = m_tdata[OUT_W-2:0];
            if (expected_colors.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
            end
            else begin
                exp_c = expected_colors.pop_front();
                if (got.ch0 != exp_c.ch0) begin
                    $error("channel_0 exp %0d got %0d", exp_c.ch0, got.ch0); errors++;
                end
                if (got.ch1 != exp_c.ch1) begin
                    $error("channel_1 exp %0d got %0d", exp_c.ch1, got.ch1); errors++;
                end
                if (got.ch2 != exp_c.ch2) begin
                    $error("channel_2 exp %0d got %0d", exp_c.ch2, got.ch2); errors++;
                end
                if (got.ch3 != exp_c.ch3) begin
                    $error("channel_3 exp %0d got %0d", exp_c.ch3, got.ch3); errors++;
                end
                if (got.gp != exp_c.gp) begin
                    $error("gradient_position exp %0d got %0d", exp_c.gp, got.gp); errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted item
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("** keyframe_gradient_color: FAILED **");
            $finish;
        end
    end

    initial begin
        mdl_ncolors = COLOR_COUNT_RST;
        mdl_pal[0] = PAL0_RST; mdl_pal[1] = PAL1_RST;
        mdl_pal[2] = PAL2_RST; mdl_pal[3] = PAL3_RST;
        mdl_nkeys = KF_COUNT_RST;
        mdl_ktimes = KF_TIMES_RST;
        mdl_klevels = KF_LEVELS_RST;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_values();
        test_extremes();
        test_backpressure();
        test_random(1300);
        drain();
        if (errors == 0)
            $display("** keyframe_gradient_color: PASSED **");
        else
            $display("** keyframe_gradient_color: FAILED **");
        $finish;
    end

endmodule

// ===== keyframe_gradient_color.f =====
rtl/kgc_pkg.sv
rtl/kgc_mod.sv
rtl/kgc_seg.sv
rtl/kgc_div.sv
rtl/kgc_blend.sv
rtl/keyframe_gradient_color.sv
dv/tb_keyframe_gradient_color.sv
